### design/a64ie_pkg.sv
// Package for the A64 data-processing-immediate execute block.
// Holds field widths, instruction codes, stream bit positions and shared types.
// No dependencies.
`default_nettype none

package a64ie_pkg;

	// Default register file depth and field widths.
	localparam int NUM_REGS_DEF = 31;
	localparam int REG_W        = 5;
	localparam int DATA_W       = 64;
	localparam int OPND_W       = 19;
	localparam int CMD_W        = 3;
	localparam int VAR_W        = 2;

	// Register index 31 names the stack pointer or zero register, which is not handled.
	localparam logic [REG_W-1:0] REG_ZR = 5'd31;

	// Instruction groups.
	localparam logic [CMD_W-1:0] CMD_ARITH = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MOVE  = 3'd5;

	// Arithmetic variant bits: bit 0 sets flags, bit 1 selects subtract.
	localparam int VAR_SETFLAGS_BIT = 0;
	localparam int VAR_SUB_BIT      = 1;

	// Wide move variants.
	localparam logic [VAR_W-1:0] VAR_MOVN     = 2'd0;
	localparam logic [VAR_W-1:0] VAR_MOV_RSVD = 2'd1;
	localparam logic [VAR_W-1:0] VAR_MOVZ     = 2'd2;
	localparam logic [VAR_W-1:0] VAR_MOVK     = 2'd3;

	localparam logic [DATA_W-1:0] MASK32  = 64'h0000_0000_FFFF_FFFF;
	localparam logic [DATA_W-1:0] HW_MASK = 64'h0000_0000_0000_FFFF;

	// Stream widths and result bit positions.
	localparam int IN_TDATA_W   = 32;
	localparam int OUT_TDATA_W  = 80;
	localparam int OUT_WE_BIT   = 0;
	localparam int OUT_WREG_LSB = 1;
	localparam int OUT_WVAL_LSB = 6;
	localparam int OUT_WVAL_MSB = 69;
	localparam int OUT_INV_BIT  = 74;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} nzcv_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [VAR_W-1:0]  variant;
		logic              wide;
		logic [OPND_W-1:0] operand;
		logic [REG_W-1:0]  rd;
	} instr_t;

	typedef struct packed {
		logic              we;
		logic [REG_W-1:0]  wreg;
		logic [DATA_W-1:0] wval;
		nzcv_t             flags;
		logic              invalid;
	} exec_res_t;

endpackage

`default_nettype wire

### design/a64ie_alu.sv
// Combinational execute unit: add/sub immediate with flags and wide moves.
// Depends on a64ie_pkg for the instruction and result types.
`default_nettype none

module a64ie_alu import a64ie_pkg::*; (
	input  instr_t            instr,
	input  logic              rd_ok,
	input  logic              rn_ok,
	input  logic [DATA_W-1:0] rn_val,
	input  logic [DATA_W-1:0] rd_val,
	input  nzcv_t             flags_in,
	output exec_res_t         res
);

	logic [DATA_W-1:0] mask;
	logic [DATA_W-1:0] imm;
	logic [DATA_W-1:0] a;
	logic [DATA_W-1:0] r_arith;
	logic [DATA_W-1:0] ovf_vec;
	logic              is_sub;
	nzcv_t             arith_flags;
	logic [5:0]        shamt;
	logic [DATA_W-1:0] op_w;
	logic [DATA_W-1:0] keep_mask;
	logic [DATA_W-1:0] r_move;

	assign mask = instr.wide ? '1 : MASK32;

	// Add or subtract of the 12-bit immediate, optionally shifted by 12.
	always_comb begin
		imm = instr.operand[17] ? {40'b0, instr.operand[16:5], 12'b0}
		                        : {52'b0, instr.operand[16:5]};
		is_sub = instr.variant[VAR_SUB_BIT];
		a = rn_val & mask;
		r_arith = (is_sub ? (a - imm) : (a + imm)) & mask;
		ovf_vec = is_sub ? ((a ^ imm) & (a ^ r_arith)) : ((a ^ r_arith) & (imm ^ r_arith));
		arith_flags.n = instr.wide ? r_arith[63] : r_arith[31];
		arith_flags.z = (r_arith == '0);
		arith_flags.c = is_sub ? (a >= imm) : (r_arith < a);
		arith_flags.v = instr.wide ? ovf_vec[63] : ovf_vec[31];
	end

	// Wide move of a 16-bit immediate at halfword position hw.
	always_comb begin
		shamt = {instr.operand[17:16], 4'b0};
		op_w = ({48'b0, instr.operand[15:0]} << shamt) & mask;
		keep_mask = ~(HW_MASK << shamt);
		unique case (instr.variant)
			VAR_MOVN: r_move = ~op_w & mask;
			VAR_MOVZ: r_move = op_w;
			VAR_MOVK: r_move = ((rd_val & keep_mask) | op_w) & mask;
			default:  r_move = '0;
		endcase
	end

	// Result selection by instruction group.
	always_comb begin
		res = '0;
		res.flags = flags_in;
		unique case (instr.cmd)
			CMD_ARITH: begin
				if (rd_ok && rn_ok) begin
					res.we = 1'b1;
					res.wreg = instr.rd;
					res.wval = r_arith;
					if (instr.variant[VAR_SETFLAGS_BIT]) begin
						res.flags = arith_flags;
					end
				end
			end
			CMD_MOVE: begin
				if (instr.variant == VAR_MOV_RSVD) begin
					res.invalid = 1'b1;
				end else if (rd_ok) begin
					res.we = 1'b1;
					res.wreg = instr.rd;
					res.wval = r_move;
				end
			end
			default: begin
				res.invalid = 1'b1;
			end
		endcase
	end

endmodule

`default_nettype wire

### design/a64_dp_immediate_execute.sv
// A64 data-processing-immediate execute block: top level.
// Depends on a64ie_pkg and a64ie_alu.
//
// Usage:
// Instructions arrive on the slave stream (s_tvalid, s_tready, s_tdata, s_tuser)
// and one result per instruction leaves on the master stream (m_tvalid,
// m_tready, m_tdata). s_tuser carries the instruction group; s_tdata carries
// variant, width, operand bits and destination register.
// The register file is read at the edge that accepts a transaction, into the
// execute stage register; the instruction executes combinationally from there,
// and the result register loads when the execute stage advances, raising m_tvalid.
// One instruction is accepted every cycle unless the receiver stalls; the rate
// is set by the single register-file read port pair feeding one execute stage,
// and a write by the instruction ahead reaches the next one through a bypass register.
// When the receiver stalls, the result register holds its transaction and the
// execute stage holds one more instruction; s_tready drops only when both are
// full. Reset clears the pipeline valid bits, the NZCV flags and the register
// valid bits, so every register reads as zero until it is first written.
`default_nettype none

module a64_dp_immediate_execute import a64ie_pkg::*; #(
	parameter int NUM_REGS = NUM_REGS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	// op_variant[1:0], wide_mode[2], operand_bits[21:3], dest_reg[26:22], zero pad
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	// cmd[2:0]
	input  logic [CMD_W-1:0]       s_tuser,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	// write_enable[0], write_reg[5:1], write_value[69:6], flag_n[70], flag_z[71],
	// flag_c[72], flag_v[73], invalid[74], zero pad
	output logic [OUT_TDATA_W-1:0] m_tdata
);

	localparam int IDX_W = $clog2(NUM_REGS);
	localparam int VLD_N = 1 << IDX_W;
	localparam logic [REG_W-1:0] NUM_REGS_L = REG_W'(NUM_REGS);

	instr_t            in_instr;
	logic              in_fire;
	logic [REG_W-1:0]  rn_in;

	instr_t            instr_s1;
	logic              vld_s1;
	logic [DATA_W-1:0] rn_data_s1;
	logic [DATA_W-1:0] rd_data_s1;
	logic              rn_vld_s1;
	logic              rd_vld_s1;
	logic              rn_byp_s1;
	logic              rd_byp_s1;
	logic [DATA_W-1:0] byp_val_s1;

	logic [DATA_W-1:0] mem [NUM_REGS];
	logic [VLD_N-1:0]  reg_vld_q;
	nzcv_t             flags_q;
	exec_res_t         out_q;
	logic              out_vld_q;

	logic              s1_adv;
	logic              wr_fire;
	logic [IDX_W-1:0]  wr_idx;
	logic [REG_W-1:0]  rn_s1;
	logic              rd_ok_s1;
	logic              rn_ok_s1;
	logic [DATA_W-1:0] rn_val_s1;
	logic [DATA_W-1:0] rd_val_s1;
	exec_res_t         res;

	// Unpack the incoming transaction.
	always_comb begin
		in_instr.cmd     = s_tuser;
		in_instr.variant = s_tdata[1:0];
		in_instr.wide    = s_tdata[2];
		in_instr.operand = s_tdata[21:3];
		in_instr.rd      = s_tdata[26:22];
	end

	assign rn_in   = in_instr.operand[REG_W-1:0];
	assign in_fire = s_tvalid && s_tready;

	// Handshake: the execute stage moves on whenever the result register is empty or being taken.
	assign s1_adv   = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || s1_adv;
	assign wr_fire  = s1_adv && res.we;
	assign wr_idx   = res.wreg[IDX_W-1:0];

	// Operand resolution: bypass first, then stored value, zero if never written.
	assign rn_s1     = instr_s1.operand[REG_W-1:0];
	assign rd_ok_s1  = (instr_s1.rd != REG_ZR) && (instr_s1.rd < NUM_REGS_L);
	assign rn_ok_s1  = (rn_s1 != REG_ZR) && (rn_s1 < NUM_REGS_L);
	assign rn_val_s1 = rn_byp_s1 ? byp_val_s1 : (rn_vld_s1 ? rn_data_s1 : '0);
	assign rd_val_s1 = rd_byp_s1 ? byp_val_s1 : (rd_vld_s1 ? rd_data_s1 : '0);

	a64ie_alu u_alu (
		.instr    (instr_s1),
		.rd_ok    (rd_ok_s1),
		.rn_ok    (rn_ok_s1),
		.rn_val   (rn_val_s1),
		.rd_val   (rd_val_s1),
		.flags_in (flags_q),
		.res      (res)
	);

	// Control state: stage valids, flags and register valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
			flags_q   <= '0;
			reg_vld_q <= '0;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (s1_adv) begin
				out_vld_q <= 1'b1;
				flags_q   <= res.flags;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
			if (wr_fire) begin
				reg_vld_q[wr_idx] <= 1'b1;
			end
		end
	end

	// Register file read at acceptance, with a bypass capture of the write made
	// at the same edge by the instruction ahead.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			instr_s1   <= in_instr;
			rn_data_s1 <= mem[rn_in[IDX_W-1:0]];
			rd_data_s1 <= mem[in_instr.rd[IDX_W-1:0]];
			rn_vld_s1  <= reg_vld_q[rn_in[IDX_W-1:0]];
			rd_vld_s1  <= reg_vld_q[in_instr.rd[IDX_W-1:0]];
			rn_byp_s1  <= wr_fire && (res.wreg == rn_in);
			rd_byp_s1  <= wr_fire && (res.wreg == in_instr.rd);
			byp_val_s1 <= res.wval;
		end
		if (wr_fire) begin
			mem[wr_idx] <= res.wval;
		end
		if (s1_adv) begin
			out_q <= res;
		end
	end

	// Pack the result transaction.
	assign m_tvalid = out_vld_q;
	assign m_tdata  = {5'b0, out_q.invalid, out_q.flags.v, out_q.flags.c, out_q.flags.z,
		out_q.flags.n, out_q.wval, out_q.wreg, out_q.we};

endmodule

`default_nettype wire

### design/a64ie_checker.sv
// Port-level checker for the A64 data-processing-immediate execute block.
// Depends on a64ie_pkg; bound to a64_dp_immediate_execute below.
`default_nettype none

module a64ie_checker import a64ie_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata
);

	// A stalled result transaction holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// With the result register empty the block always takes a new instruction.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty output");

	// An invalid encoding never writes a register.
	a_invalid_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_INV_BIT] |-> !m_tdata[OUT_WE_BIT])
		else $error("invalid instruction wrote a register");

	// Without a write, register index and value read as zero.
	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[OUT_WE_BIT] |-> m_tdata[OUT_WVAL_MSB:OUT_WREG_LSB] == '0)
		else $error("write fields nonzero without a write");

	// Register 31 is never written.
	a_no_zr_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[OUT_WE_BIT] |-> m_tdata[OUT_WVAL_LSB-1:OUT_WREG_LSB] != REG_ZR)
		else $error("register 31 written");

endmodule

bind a64_dp_immediate_execute a64ie_checker u_a64ie_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
